// ----- rtl/srp_pkg.sv -----
`default_nettype none
package srp_pkg;
  localparam int MaxPages = 8;
  localparam int PgW = 3;
  localparam int CntW = 4;
  localparam logic [1:0] CMD_PACK = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_END = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;
  localparam logic [1:0] REG_ATLAS = 2'd0;
  localparam logic [1:0] REG_MARGIN = 2'd1;
  localparam logic [1:0] REG_SEARCH = 2'd2;

  // Per-page shelf and dirty state.
  typedef struct packed {
    logic [13:0] cx;
    logic [13:0] cy;
    logic [12:0] rh;
    logic        mark;
    logic [12:0] dl;
    logic [12:0] dt;
    logic [12:0] dr;
    logic [12:0] db;
  } page_t;

  // Command from the sequencer to one cell.
  typedef struct packed {
    logic        clear;
    logic        wr;
    page_t       data;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ----- rtl/srp_cell.sv -----
`default_nettype none
// One page of the atlas; state is loaded, cleared or written by the sequencer,
// and the cell loads its contents into the read chain whenever it is not shifting.
module srp_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire srp_pkg::cell_cmd_t cmd,
  input  wire logic              shift,
  input  wire srp_pkg::page_t    chain_in,
  output srp_pkg::page_t         chain_out,
  output srp_pkg::page_t         state
);
  srp_pkg::page_t page_r, page_nxt;
  srp_pkg::page_t out_r;

  // Page state update.
  always_comb begin
    page_nxt = page_r;
    if (cmd.clear) begin
      page_nxt = '0;
    end else if (cmd.wr) begin
      page_nxt = cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '0;
    end else begin
      page_r <= page_nxt;
    end
  end

  // Scan chain stage: loads own page, or takes the neighbor's.
  always_ff @(posedge clk) begin
    if (shift) begin
      out_r <= chain_in;
    end else begin
      out_r <= page_r;
    end
  end

  assign chain_out = out_r;
  assign state = page_r;
endmodule
`default_nettype wire

// ----- rtl/shelf_rect_packer.sv -----
`default_nettype none
// Channel | Direction | Content
// in_     | input     | request: command, sizes, count, page select, clear
// out_    | output    | result: status, page, position, dirty box
// cfg_    | input     | register writes (atlas size, margin, search mode)
// End run, dirty read and empty runs go from the pick state straight to the
// result; a pack on the newest or run page goes through the place state first.
// First-fit pack scans the chain one page per cycle before it places.
// Begin run tries up to cell_count cells on each open page in turn, and opens a new page if none fits.
// Reset is synchronous; it clears all pages and the run, and sets the config registers to their defaults.
// A held result stalls the input; the next request is taken the cycle after.
module shelf_rect_packer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] command, [14:2] cell_width, [27:15] cell_height, [35:28] cell_count,
  // [38:36] page_select, [39] clear_dirty
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] status, [3:1] page_index, [16:4] x_pos, [29:17] y_pos, [30] dirty_flag,
  // [43:31] dirty_left, [56:44] dirty_top, [69:57] dirty_right,
  // [82:70] dirty_bottom
  output logic [87:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PICK = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [12:0] atlas_r;
  logic [3:0]  margin_r;
  logic        search_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_r <= 13'd512;
      margin_r <= 4'd2;
      search_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srp_pkg::REG_ATLAS:  atlas_r <= cfg_data;
        srp_pkg::REG_MARGIN: margin_r <= cfg_data[3:0];
        srp_pkg::REG_SEARCH: search_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Chain of page cells.
  srp_pkg::cell_cmd_t cmds [srp_pkg::MaxPages];
  srp_pkg::page_t     pst  [srp_pkg::MaxPages];
  srp_pkg::page_t     chn  [srp_pkg::MaxPages];
  logic shift;

  for (genvar g = 0; g < srp_pkg::MaxPages; g++) begin : g_cell
    srp_pkg::page_t cin;
    if (g == srp_pkg::MaxPages - 1) begin : g_end
      assign cin = '0;
    end else begin : g_mid
      assign cin = chn[g+1];
    end
    srp_cell u_cell (.clk(clk), .rst_n(rst_n), .cmd(cmds[g]), .shift(shift),
                     .chain_in(cin), .chain_out(chn[g]), .state(pst[g]));
  end

  // Control registers.
  logic [2:0]  st_r;
  logic [3:0]  used_r;
  logic [2:0]  run_pg_r;
  logic        run_act_r;
  logic [1:0]  cmd_r;
  logic [12:0] w_r, h_r;
  logic [7:0]  n_r, i_r;
  logic [2:0]  sel_r;
  logic        clr_r;
  logic [3:0]  scan_r;
  logic [13:0] sx_r, sy_r;
  logic [12:0] srh_r;
  logic [87:0] res_r;

  srp_pkg::page_t head;
  assign head = chn[0];

  // Fit of the chain head page (pack rule).
  logic [15:0] hx_sum, hy_wrap, hy_end;
  logic        head_fits;
  always_comb begin
    hx_sum = 16'(head.cx) + 16'(w_r) + 16'(margin_r);
    hy_wrap = 16'(head.cy);
    if (hx_sum > 16'(atlas_r)) hy_wrap = 16'(head.cy) + 16'(head.rh) + 16'(margin_r);
    hy_end = hy_wrap + 16'(h_r);
    head_fits = hy_end <= 16'(atlas_r);
  end

  // One run-fit step on the scan registers.
  logic [15:0] rx_sum, ry, rx_nx;
  logic [12:0] rrh;
  logic        rstep_ok;
  always_comb begin
    rx_sum = 16'(sx_r) + 16'(w_r) + 16'(margin_r);
    ry = 16'(sy_r);
    rrh = srh_r;
    rx_nx = rx_sum;
    if (rx_sum > 16'(atlas_r)) begin
      ry = 16'(sy_r) + 16'(srh_r) + 16'(margin_r);
      rrh = '0;
      rx_nx = 16'(w_r) + 16'(margin_r);
    end
    rstep_ok = ry + 16'(h_r) <= 16'(atlas_r);
  end

  // Placement on the chosen page.
  logic [2:0]  pg_r;
  srp_pkg::page_t cur, pw, pn;
  logic [15:0] px_sum, py_wrap;
  logic        tall, place_ok;
  logic [2:0]  place_pg;
  logic [13:0] xx, yy;
  logic [13:0] rr, bb;
  logic [15:0] nx;
  always_comb begin
    cur = pst[pg_r];
    pw = cur;
    py_wrap = '0;
    px_sum = 16'(cur.cx) + 16'(w_r) + 16'(margin_r);
    if (px_sum > 16'(atlas_r)) begin
      py_wrap = 16'(cur.cy) + 16'(cur.rh) + 16'(margin_r);
      pw.cx = '0;
      pw.cy = py_wrap > 16'd16383 ? 14'd16383 : py_wrap[13:0];
      pw.rh = '0;
    end
    tall = 16'(pw.cy) + 16'(h_r) > 16'(atlas_r);
    place_ok = !tall || used_r < 4'(srp_pkg::MaxPages);
    place_pg = tall ? used_r[2:0] : pg_r;
    pn = tall ? '0 : pw;
    xx = pn.cx;
    yy = pn.cy;
    rr = 14'(xx) + 14'(w_r);
    if (15'(xx) + 15'(w_r) > 15'd8191) rr = 14'd8191;
    bb = 14'(yy) + 14'(h_r);
    if (15'(yy) + 15'(h_r) > 15'd8191) bb = 14'd8191;
    if (w_r != 0 && h_r != 0) begin
      if (!pn.mark) begin
        pn.dl = xx[12:0]; pn.dt = yy[12:0]; pn.dr = rr[12:0]; pn.db = bb[12:0];
        pn.mark = 1'b1;
      end else begin
        if (13'(xx) < pn.dl) pn.dl = xx[12:0];
        if (13'(yy) < pn.dt) pn.dt = yy[12:0];
        if (rr[12:0] > pn.dr) pn.dr = rr[12:0];
        if (bb[12:0] > pn.db) pn.db = bb[12:0];
      end
    end
    nx = 16'(xx) + 16'(w_r) + 16'(margin_r);
    pn.cx = nx > 16'd16383 ? 14'd16383 : nx[13:0];
    if (h_r > pn.rh) pn.rh = h_r;
  end

  logic [2:0] scan_pg;
  assign scan_pg = scan_r[2:0];

  always_comb begin
    for (int k = 0; k < srp_pkg::MaxPages; k++) cmds[k] = '0;
    shift = st_r == S_RUN;
    if (st_r == S_PICK && cmd_r == srp_pkg::CMD_PACK && used_r == 0) cmds[0].clear = 1'b1;
    if (st_r == S_PLACE) begin
      if (tall) begin
        // The wrap stays on the old page even when a new page takes the cell.
        cmds[pg_r].wr = 1'b1; cmds[pg_r].data = pw;
        if (place_ok) begin
          cmds[place_pg].wr = 1'b1; cmds[place_pg].data = pn;
        end
      end else begin
        cmds[pg_r].wr = 1'b1; cmds[pg_r].data = pn;
      end
    end
    if (st_r == S_RUN && scan_r == used_r && used_r < 4'(srp_pkg::MaxPages)
        && cmd_r == srp_pkg::CMD_PACK) cmds[used_r[2:0]].clear = 1'b1;
    if (st_r == S_RUN && scan_r == used_r && used_r < 4'(srp_pkg::MaxPages)
        && cmd_r == srp_pkg::CMD_BEGIN) cmds[used_r[2:0]].clear = 1'b1;
    if (st_r == S_PICK && cmd_r == srp_pkg::CMD_READ && clr_r && 4'(sel_r) < used_r)
      cmds[sel_r].wr = 1'b1;
    if (st_r == S_PICK && cmd_r == srp_pkg::CMD_READ) begin
      cmds[sel_r].data = pst[sel_r];
      cmds[sel_r].data.mark = 1'b0;
    end
  end

  assign in_tready = st_r == S_IDLE;
  assign out_tvalid = st_r == S_OUT;
  assign out_tdata = res_r;

  // Sequencer: pick page, scan chain or run steps, place, deliver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; used_r <= '0; run_pg_r <= '0; run_act_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_tvalid) begin
          cmd_r <= in_tdata[1:0]; w_r <= in_tdata[14:2]; h_r <= in_tdata[27:15];
          n_r <= in_tdata[35:28]; sel_r <= in_tdata[38:36]; clr_r <= in_tdata[39];
          res_r <= '0; st_r <= S_PICK;
        end
        S_PICK: begin
          scan_r <= '0;
          unique case (cmd_r)
            srp_pkg::CMD_PACK: begin
              if (used_r == 0) used_r <= 4'd1;
              if (run_act_r && 4'(run_pg_r) < used_r) begin
                pg_r <= run_pg_r; st_r <= S_PLACE;
              end else if (search_r) begin
                st_r <= S_RUN;
              end else begin
                pg_r <= used_r == 0 ? 3'd0 : 3'(used_r - 4'd1); st_r <= S_PLACE;
              end
            end
            srp_pkg::CMD_BEGIN: begin
              run_act_r <= 1'b0;
              if (n_r == 0 || w_r == 0 || h_r == 0) st_r <= S_OUT;
              else begin
                st_r <= S_RUN; i_r <= '0;
                sx_r <= pst[0].cx; sy_r <= pst[0].cy; srh_r <= pst[0].rh;
              end
            end
            srp_pkg::CMD_END: begin
              run_act_r <= 1'b0; st_r <= S_OUT;
            end
            default: begin
              res_r[3:1] <= sel_r;
              if (4'(sel_r) < used_r) begin
                res_r[30] <= pst[sel_r].mark;
                res_r[43:31] <= pst[sel_r].dl; res_r[56:44] <= pst[sel_r].dt;
                res_r[69:57] <= pst[sel_r].dr; res_r[82:70] <= pst[sel_r].db;
              end
              st_r <= S_OUT;
            end
          endcase
        end
        S_RUN: begin
          if (cmd_r == srp_pkg::CMD_PACK) begin
            // Chain head holds page scan_r (one shift per cycle after load).
            if (scan_r == used_r) begin
              if (used_r < 4'(srp_pkg::MaxPages)) begin
                pg_r <= used_r[2:0]; used_r <= used_r + 4'd1; st_r <= S_PLACE;
              end else begin
                res_r[0] <= 1'b1; st_r <= S_OUT;
              end
            end else if (head_fits) begin
              pg_r <= scan_pg; st_r <= S_PLACE;
            end else begin
              scan_r <= scan_r + 4'd1;
            end
          end else begin
            if (scan_r == used_r) begin
              if (used_r < 4'(srp_pkg::MaxPages)) begin
                run_pg_r <= used_r[2:0]; run_act_r <= 1'b1; res_r[3:1] <= used_r[2:0];
                used_r <= used_r + 4'd1;
              end else res_r[0] <= 1'b1;
              st_r <= S_OUT;
            end else if (!rstep_ok || i_r == n_r) begin
              if (rstep_ok || i_r == n_r) begin
                run_pg_r <= scan_pg; run_act_r <= 1'b1; res_r[3:1] <= scan_pg;
                st_r <= S_OUT;
              end else begin
                scan_r <= scan_r + 4'd1; i_r <= '0;
                if (scan_r + 4'd1 < 4'(srp_pkg::MaxPages)) begin
                  sx_r <= pst[3'(scan_r + 4'd1)].cx; sy_r <= pst[3'(scan_r + 4'd1)].cy;
                  srh_r <= pst[3'(scan_r + 4'd1)].rh;
                end
              end
            end else begin
              i_r <= i_r + 8'd1;
              sx_r <= rx_nx[13:0]; sy_r <= ry[13:0];
              srh_r <= h_r > rrh ? h_r : rrh;
            end
          end
        end
        S_PLACE: begin
          if (!place_ok) res_r[0] <= 1'b1;
          else begin
            if (tall) used_r <= used_r + 4'd1;
            res_r[3:1] <= place_pg; res_r[16:4] <= xx[12:0]; res_r[29:17] <= yy[12:0];
          end
          st_r <= S_OUT;
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= 4'(srp_pkg::MaxPages)) else $error("page count overflow");
  a_hs: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("accept while result pending");
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_act_r |-> 4'(run_pg_r) < used_r) else $error("run page not open");
`endif
endmodule
`default_nettype wire
